@@ hw/rtl/fdc_pkg.sv @@
// fdc_pkg: shared types, codes and the byte-wide crc-16 update for the frame deframer
// no dependencies

package fdc_pkg;

   // width of the wrapping frame counters
   localparam int COUNTER_WIDTH = 32;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   // configuration register indexes
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_LEN_LIMIT   = 2'd2;

   localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
   localparam logic [15:0] LEN_LIMIT_RESET   = 16'd1024;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_CRC_BAD  = 2'd2,
      KIND_TOO_LONG = 2'd3
   } kind_type;

   typedef enum logic {
      OP_BYTE   = 1'b0,
      OP_RESYNC = 1'b1
   } op_type;

   // classified word handed from front to back
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       is_first;
      logic       is_second;
   } word_type;

   // crc-16/ccitt-false update by one byte, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/fdc_if.sv @@
// fdc_req_if / fdc_rsp_if: valid-ready channels of the frame deframer
// no dependencies

interface fdc_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface fdc_rsp_if;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [7:0]  msg_type;
   logic [7:0]  command;
   logic [15:0] payload_length;
   logic [31:0] accepted_count;
   logic [31:0] rejected_count;
   logic        valid;
   logic        ready;

   modport source (output valid, output kind, output data_byte, output msg_type,
                   output command, output payload_length, output accepted_count,
                   output rejected_count, input ready);
   modport sink   (input valid, input kind, input data_byte, input msg_type,
                   input command, input payload_length, input accepted_count,
                   input rejected_count, output ready);
endinterface

@@ hw/rtl/fdc_front.sv @@
// fdc_front: accepts input words and classifies them for the parser
// depends on fdc_pkg, fdc_if

module fdc_front (
   fdc_req_if.sink            req,
   input  logic [7:0]         sync_first,
   input  logic [7:0]         sync_second,
   input  logic               queue_full,
   output logic               push,
   output fdc_pkg::word_type  push_word
);

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      push_word.op        = req.func ? fdc_pkg::OP_RESYNC : fdc_pkg::OP_BYTE;
      push_word.data      = req.rx_byte;
      // sync matches against the registers, taken here as the word enters
      push_word.is_first  = (req.rx_byte == sync_first);
      push_word.is_second = (req.rx_byte == sync_second);
   end

endmodule

@@ hw/rtl/fdc_queue.sv @@
// fdc_queue: two-entry word queue between front and back
// depends on fdc_pkg

module fdc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fdc_pkg::word_type  push_word,
   output logic               full,
   output logic               avail,
   input  logic               pop,
   output fdc_pkg::word_type  pop_word
);

   fdc_pkg::word_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign avail    = (count_ff != 2'd0);
   assign do_pop   = pop && avail;
   assign pop_word = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

@@ hw/rtl/fdc_back.sv @@
// fdc_back: frame parser, crc check, counters and result register
// depends on fdc_pkg, fdc_if

module fdc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        len_limit,
   input  logic               avail,
   input  fdc_pkg::word_type  word,
   output logic               pop,
   fdc_rsp_if.source          rsp
);

   typedef enum logic [3:0] {
      PH_SYNC1, PH_SYNC2, PH_TYPE, PH_CMD, PH_LENH, PH_LENL,
      PH_PAYLOAD, PH_CRCH, PH_CRCL
   } phase_type;

   localparam int CW = fdc_pkg::COUNTER_WIDTH;

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  crch_ff, crch_in;
   logic [15:0] crc_ff, crc_in;
   logic [CW-1:0] good_ff, good_in;
   logic [CW-1:0] bad_ff, bad_in;

   logic              rsp_valid_ff, rsp_valid_in;
   fdc_pkg::kind_type kind_ff, kind_in;
   logic [7:0]        data_ff, data_in;
   logic [7:0]        res_type_ff;
   logic [7:0]        res_cmd_ff;
   logic [15:0]       res_len_ff;
   logic [31:0]       res_good_ff;
   logic [31:0]       res_bad_ff;
   logic              emit;
   logic [15:0]       crc_step;

   // result slot free or draining this cycle
   assign pop      = avail && (!rsp_valid_ff || rsp.ready);
   assign crc_step = fdc_pkg::crc_byte(crc_ff, word.data);

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      left_in  = left_ff;
      crch_in  = crch_ff;
      crc_in   = crc_ff;
      good_in  = good_ff;
      bad_in   = bad_ff;
      emit     = 1'b0;
      kind_in  = kind_ff;
      data_in  = data_ff;
      if (pop) begin
         if (word.op == fdc_pkg::OP_RESYNC) begin
            phase_in = PH_SYNC1;
         end else begin
            case (phase_ff)
               PH_SYNC1: begin
                  if (word.is_first) begin
                     crc_in   = fdc_pkg::crc_byte(fdc_pkg::CRC_INIT, word.data);
                     phase_in = PH_SYNC2;
                  end
               end
               PH_SYNC2: begin
                  if (word.is_second) begin
                     crc_in   = crc_step;
                     phase_in = PH_TYPE;
                  end else begin
                     phase_in = PH_SYNC1;
                  end
               end
               PH_TYPE: begin
                  type_in  = word.data;
                  crc_in   = crc_step;
                  phase_in = PH_CMD;
               end
               PH_CMD: begin
                  cmd_in   = word.data;
                  crc_in   = crc_step;
                  phase_in = PH_LENH;
               end
               PH_LENH: begin
                  len_in   = {word.data, 8'h00};
                  crc_in   = crc_step;
                  phase_in = PH_LENL;
               end
               PH_LENL: begin
                  len_in  = {len_ff[15:8], word.data};
                  crc_in  = crc_step;
                  left_in = len_in;
                  if (len_in > len_limit) begin
                     bad_in   = bad_ff + CW'(1);
                     phase_in = PH_SYNC1;
                     emit     = 1'b1;
                     kind_in  = fdc_pkg::KIND_TOO_LONG;
                     data_in  = 8'h00;
                  end else if (len_in == 16'h0000) begin
                     phase_in = PH_CRCH;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  crc_in  = crc_step;
                  left_in = left_ff - 16'd1;
                  if (left_in == 16'h0000) begin
                     phase_in = PH_CRCH;
                  end
                  emit    = 1'b1;
                  kind_in = fdc_pkg::KIND_PAYLOAD;
                  data_in = word.data;
               end
               PH_CRCH: begin
                  crch_in  = word.data;
                  phase_in = PH_CRCL;
               end
               PH_CRCL: begin
                  phase_in = PH_SYNC1;
                  emit     = 1'b1;
                  data_in  = 8'h00;
                  if ({crch_ff, word.data} == crc_ff) begin
                     good_in = good_ff + CW'(1);
                     kind_in = fdc_pkg::KIND_GOOD;
                  end else begin
                     bad_in  = bad_ff + CW'(1);
                     kind_in = fdc_pkg::KIND_CRC_BAD;
                  end
               end
               default: begin
                  phase_in = PH_SYNC1;
               end
            endcase
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         type_ff      <= 8'h00;
         cmd_ff       <= 8'h00;
         len_ff       <= 16'h0000;
         left_ff      <= 16'h0000;
         crch_ff      <= 8'h00;
         crc_ff       <= fdc_pkg::CRC_INIT;
         good_ff      <= '0;
         bad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         type_ff      <= type_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
         crch_ff      <= crch_in;
         crc_ff       <= crc_in;
         good_ff      <= good_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         kind_ff     <= kind_in;
         data_ff     <= data_in;
         res_type_ff <= type_in;
         res_cmd_ff  <= cmd_in;
         res_len_ff  <= len_in;
         res_good_ff <= 32'(good_in);
         res_bad_ff  <= 32'(bad_in);
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.data_byte      = data_ff;
   assign rsp.msg_type       = res_type_ff;
   assign rsp.command        = res_cmd_ff;
   assign rsp.payload_length = res_len_ff;
   assign rsp.accepted_count = res_good_ff;
   assign rsp.rejected_count = res_bad_ff;

endmodule

@@ hw/rtl/frame_deframer_crc16.sv @@
// frame_deframer_crc16: top level of the sync/length framed packet parser
// depends on fdc_pkg, fdc_if, fdc_front, fdc_queue, fdc_back

// Byte-serial frame parser. Each req word is either a received byte (func 0) or a
// resync request (func 1). The parser hunts for sync_first then sync_second, reads
// type, command and a big-endian 16-bit length, streams each payload byte out as a
// kind 0 rsp word, then checks a big-endian crc-16/ccitt-false (poly 0x1021, init
// 0xffff, no reflection, no final xor) over everything before the crc and reports
// kind 1 (good) or kind 2 (crc mismatch). A length above the length limit register
// gives kind 3 at once and goes back to hunting. Payload is not buffered: drop a frame
// whose end word is bad. One word per clock is sustained while rsp is taken, the figure
// set by the byte-wide crc update in the parser. The req word lands in a queue slot at
// the edge that accepts it; its rsp word, if any, is registered in the result register
// when the parser pops the word, which a full result register can hold off. Write
// configuration only while idle; writes to an unused index are ignored.

module frame_deframer_crc16 (
   input  logic        clock,
   input  logic        reset,
   fdc_req_if.sink     req,
   fdc_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic [7:0]  sync_first_ff;
   logic [7:0]  sync_second_ff;
   logic [15:0] len_limit_ff;

   // front to queue
   logic              push;
   fdc_pkg::word_type push_word;
   logic              queue_full;

   // queue to back
   logic              avail;
   logic              pop;
   fdc_pkg::word_type pop_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= fdc_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= fdc_pkg::SYNC_SECOND_RESET;
         len_limit_ff   <= fdc_pkg::LEN_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fdc_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[7:0];
            fdc_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[7:0];
            fdc_pkg::CSR_LEN_LIMIT:   len_limit_ff   <= csr_wdata;
            default: ; // unused index, write dropped
         endcase
      end
   end

   // classify incoming words and compare against the sync bytes
   fdc_front u_front (
      .req         (req),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_word   (push_word)
   );

   // short queue so front and back stall independently
   fdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .avail     (avail),
      .pop       (pop),
      .pop_word  (pop_word)
   );

   // parser state machine, crc, counters and the rsp register
   fdc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .len_limit   (len_limit_ff),
      .avail       (avail),
      .word        (pop_word),
      .pop         (pop),
      .rsp         (rsp)
   );

endmodule

@@ sim/frame_deframer_crc16_tb.sv @@
`timescale 1ns / 100ps
// frame_deframer_crc16_tb: self-checking bench for the sync/length framed parser with crc-16
// depends on fdc_pkg, fdc_if and the frame_deframer_crc16 rtl; predicts every rsp word in-bench

module frame_deframer_crc16_tb;

   // parser position while following the byte stream
   typedef enum logic [3:0] {
      HUNT_FIRST, HUNT_SECOND, GET_TYPE, GET_CMD, GET_LEN_HI, GET_LEN_LO,
      GET_PAYLOAD, GET_CRC_HI, GET_CRC_LO
   } parse_phase_type;

   // how a generated frame is damaged, if at all
   typedef enum logic [1:0] {
      FRAME_GOOD, FRAME_BAD_CRC, FRAME_CUT, FRAME_SLIP
   } frame_shape_type;

   // one rsp word as the parser should emit it
   typedef struct {
      fdc_pkg::kind_type kind;
      logic [7:0]  data;
      logic [7:0]  mtype;
      logic [7:0]  cmd;
      logic [15:0] len;
      logic [31:0] good_cnt;
      logic [31:0] bad_cnt;
   } rsp_word_type;

   localparam logic [1:0] CSR_UNUSED     = 2'd3;
   localparam int         TIMEOUT_CYCLES = 1_000_000;
   localparam int         RANDOM_WORDS   = 1850;
   localparam int         CW             = fdc_pkg::COUNTER_WIDTH;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   fdc_req_if req_ch ();
   fdc_rsp_if rsp_ch ();

   frame_deframer_crc16 uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register copies as the block should hold them
   logic [7:0]  cfg_sync1 = fdc_pkg::SYNC_FIRST_RESET;
   logic [7:0]  cfg_sync2 = fdc_pkg::SYNC_SECOND_RESET;
   logic [15:0] cfg_max   = fdc_pkg::LEN_LIMIT_RESET;

   // parser state mirrored word by word
   parse_phase_type          phase_m   = HUNT_FIRST;
   logic [7:0]               type_m    = 8'h00;
   logic [7:0]               cmd_m     = 8'h00;
   logic [15:0]              len_m     = 16'h0000;
   logic [15:0]              left_m    = 16'h0000;
   logic [7:0]               crc_hi_m  = 8'h00;
   logic [15:0]              crc_m     = fdc_pkg::CRC_INIT;
   logic [CW-1:0]            good_m    = '0;
   logic [CW-1:0]            bad_m     = '0;

   rsp_word_type words_due[$];   // rsp words owed by the parser, oldest first

   int mismatches    = 0;
   int burst_left    = 0;
   int traffic_words = 0;
   bit quiet         = 1'b0;     // no gaps and no stalls while set

   // crc-16/ccitt-false, fed one data bit at a time from the msb
   function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ fdc_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   // advance the mirrored parser by one accepted req word, queue any rsp word it owes
   function automatic void parse_step(fdc_pkg::op_type op, logic [7:0] b);
      rsp_word_type w;
      logic         fire;
      w.kind = fdc_pkg::KIND_PAYLOAD;
      w.data = 8'h00;
      fire   = 1'b0;
      if (op == fdc_pkg::OP_RESYNC) begin
         phase_m = HUNT_FIRST;
         return;
      end
      case (phase_m)
         HUNT_FIRST: begin
            if (b == cfg_sync1) begin
               crc_m   = crc16_next(fdc_pkg::CRC_INIT, b);
               phase_m = HUNT_SECOND;
            end
         end
         HUNT_SECOND: begin
            // a wrong second byte is dropped, not retried as a first sync
            if (b == cfg_sync2) begin
               crc_m   = crc16_next(crc_m, b);
               phase_m = GET_TYPE;
            end else begin
               phase_m = HUNT_FIRST;
            end
         end
         GET_TYPE: begin
            type_m  = b;
            crc_m   = crc16_next(crc_m, b);
            phase_m = GET_CMD;
         end
         GET_CMD: begin
            cmd_m   = b;
            crc_m   = crc16_next(crc_m, b);
            phase_m = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            len_m   = {b, 8'h00};
            crc_m   = crc16_next(crc_m, b);
            phase_m = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            len_m[7:0] = b;
            crc_m      = crc16_next(crc_m, b);
            left_m     = len_m;
            if (len_m > cfg_max) begin
               bad_m   = bad_m + CW'(1);
               phase_m = HUNT_FIRST;
               w.kind  = fdc_pkg::KIND_TOO_LONG;
               fire    = 1'b1;
            end else if (len_m == 16'h0000) begin
               phase_m = GET_CRC_HI;
            end else begin
               phase_m = GET_PAYLOAD;
            end
         end
         GET_PAYLOAD: begin
            crc_m  = crc16_next(crc_m, b);
            left_m = left_m - 16'd1;
            if (left_m == 16'h0000) begin
               phase_m = GET_CRC_HI;
            end
            w.data = b;
            fire   = 1'b1;
         end
         GET_CRC_HI: begin
            crc_hi_m = b;
            phase_m  = GET_CRC_LO;
         end
         GET_CRC_LO: begin
            phase_m = HUNT_FIRST;
            if ({crc_hi_m, b} == crc_m) begin
               good_m = good_m + CW'(1);
               w.kind = fdc_pkg::KIND_GOOD;
            end else begin
               bad_m  = bad_m + CW'(1);
               w.kind = fdc_pkg::KIND_CRC_BAD;
            end
            fire = 1'b1;
         end
         default: begin
            phase_m = HUNT_FIRST;
         end
      endcase
      if (fire) begin
         w.mtype    = type_m;
         w.cmd      = cmd_m;
         w.len      = len_m;
         w.good_cnt = good_m[31:0];
         w.bad_cnt  = bad_m[31:0];
         words_due.insert(words_due.size(), w);
      end
   endfunction

   // one line per mismatch, and a count
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   // rsp side: ready follows a stall pattern that is picked anew at random, periodically
   int         pace_cycle = 0;
   int         pace_mode  = 0;
   int         stall_left = 0;
   logic [7:0] pace_mask  = 8'hFF;

   always @(negedge clock) begin : rsp_pacing
      logic take;
      pace_cycle++;
      if (pace_cycle % 300 == 0) begin
         pace_mode = $urandom_range(0, 3);
         pace_mask = 8'($urandom_range(1, 255));
      end
      case (pace_mode)
         0: take = 1'b1;
         1: take = 1'($urandom_range(0, 1));
         2: take = pace_mask[pace_cycle % 8];
         default: begin
            // long stalls now and then
            if (stall_left > 0) begin
               take = 1'b0;
               stall_left--;
            end else begin
               take = 1'b1;
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(1, 20);
               end
            end
         end
      endcase
      if (quiet) begin
         take = 1'b1;
      end
      rsp_ch.ready <= take;
   end

   // every rsp word taken is checked against the oldest word owed
   always @(posedge clock) begin : rsp_check
      rsp_word_type w;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (words_due.size() == 0) begin
            report_mismatch("unexpected word, kind", 32'(rsp_ch.kind), 32'h0);
         end else begin
            w = words_due.pop_front();
            if (rsp_ch.kind !== w.kind)
               report_mismatch("kind", 32'(rsp_ch.kind), 32'(w.kind));
            if (rsp_ch.data_byte !== w.data)
               report_mismatch("data_byte", 32'(rsp_ch.data_byte), 32'(w.data));
            if (rsp_ch.msg_type !== w.mtype)
               report_mismatch("msg_type", 32'(rsp_ch.msg_type), 32'(w.mtype));
            if (rsp_ch.command !== w.cmd)
               report_mismatch("command", 32'(rsp_ch.command), 32'(w.cmd));
            if (rsp_ch.payload_length !== w.len)
               report_mismatch("payload_length", 32'(rsp_ch.payload_length), 32'(w.len));
            if (rsp_ch.accepted_count !== w.good_cnt)
               report_mismatch("accepted_count", rsp_ch.accepted_count, w.good_cnt);
            if (rsp_ch.rejected_count !== w.bad_cnt)
               report_mismatch("rejected_count", rsp_ch.rejected_count, w.bad_cnt);
         end
      end
   end

   // offer one req word at the falling edge and hold it until taken; valid stays high on
   // return so that back-to-back words need no second assignment in one step
   task automatic send_word(fdc_pkg::op_type op, logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = quiet ? 64 : $urandom_range(1, 40);
         gap        = 0;
         if (!quiet && $urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
         end
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.func    <= op;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      parse_step(op, b);
      traffic_words++;
      @(negedge clock);
   endtask

   // stop sending until every owed word is back, then let the pipe empty of silent words
   task automatic drain_results();
      int spins;
      req_ch.valid <= 1'b0;
      spins = 0;
      while (words_due.size() != 0 && spins < 20000) begin
         @(negedge clock);
         spins++;
      end
      if (words_due.size() != 0) begin
         report_mismatch("words never returned", 32'(words_due.size()), 32'h0);
         words_due.delete();
      end
      repeat (6) @(negedge clock);
      burst_left = 0;
   endtask

   // register write, only ever issued with the parser drained
   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         fdc_pkg::CSR_SYNC_FIRST:  cfg_sync1 = val[7:0];
         fdc_pkg::CSR_SYNC_SECOND: cfg_sync2 = val[7:0];
         fdc_pkg::CSR_LEN_LIMIT:   cfg_max   = val;
         default: ;
      endcase
   endtask

   // build a frame for the current sync setting and send it, damaged as asked
   task automatic send_frame(frame_shape_type shape, logic [15:0] len,
                             logic [7:0] mt, logic [7:0] cm);
      logic [7:0]  line[$];
      logic [7:0]  slip;
      logic [15:0] crc;
      int          pl;
      int          k;
      if (shape == FRAME_SLIP) begin
         // often the first sync value again, which must not restart the hunt
         slip = ($urandom_range(0, 1) == 0) ? cfg_sync1 : 8'($urandom);
         while (slip == cfg_sync2) begin
            slip = 8'($urandom);
         end
         line = {cfg_sync1, slip};
      end else begin
         line = {cfg_sync1, cfg_sync2, mt, cm, len[15:8], len[7:0]};
         if (len <= cfg_max) begin
            // long frames are only started, then abandoned
            if (len > 16'd64) begin
               shape = FRAME_CUT;
            end
            pl = (len > 16'd72) ? 72 : int'(len);
            repeat (pl) line.insert(line.size(), 8'($urandom));
            if (pl == int'(len)) begin
               crc = fdc_pkg::CRC_INIT;
               foreach (line[i]) crc = crc16_next(crc, line[i]);
               if (shape == FRAME_BAD_CRC) begin
                  crc = crc ^ (16'h0001 << $urandom_range(0, 15));
               end
               line.insert(line.size(), crc[15:8]);
               line.insert(line.size(), crc[7:0]);
            end
         end
      end
      k = (shape == FRAME_CUT) ? $urandom_range(1, line.size() - 1) : line.size();
      for (int i = 0; i < k; i++) begin
         send_word(fdc_pkg::OP_BYTE, line[i]);
      end
      if (shape == FRAME_CUT) begin
         send_word(fdc_pkg::OP_RESYNC, 8'($urandom));
      end
   endtask

   // idle-line filler: bytes that cannot start a frame, and the odd resync
   task automatic send_noise(int n);
      logic [7:0] b;
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            send_word(fdc_pkg::OP_RESYNC, 8'($urandom));
         end else begin
            b = 8'($urandom);
            while (b == cfg_sync1) begin
               b = 8'($urandom);
            end
            send_word(fdc_pkg::OP_BYTE, b);
         end
      end
   endtask

   // fully random words, then a resync to get back in step
   task automatic send_chaos(int n);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            send_word(fdc_pkg::OP_RESYNC, 8'($urandom));
         end else begin
            send_word(fdc_pkg::OP_BYTE, 8'($urandom));
         end
      end
      send_word(fdc_pkg::OP_RESYNC, 8'($urandom));
   endtask

   // mostly small lengths, with the limit and one past it hit often
   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 16'($urandom_range(0, 8));
      if (r < 70) return 16'($urandom_range(9, 40));
      if (r < 80) return cfg_max;
      if (r < 90) return (cfg_max == 16'hFFFF) ? cfg_max : cfg_max + 16'd1;
      return 16'($urandom);
   endfunction

   // second sync wrong and equal to the first, then a zero-length frame with extreme fields
   task automatic test_sync_slip();
      send_word(fdc_pkg::OP_BYTE, cfg_sync1);
      send_word(fdc_pkg::OP_BYTE, cfg_sync1);
      send_frame(FRAME_GOOD, 16'h0000, 8'hFF, 8'h00);
   endtask

   // one payload byte then a corrupted crc
   task automatic test_crc_mismatch();
      send_frame(FRAME_BAD_CRC, 16'h0001, 8'h00, 8'hFF);
   endtask

   // largest length field against the reset limit
   task automatic test_length_limit();
      send_frame(FRAME_GOOD, 16'hFFFF, 8'h5A, 8'hA5);
   endtask

   // resync straight after a good sync pair, rx_byte all ones and ignored
   task automatic test_resync();
      send_word(fdc_pkg::OP_BYTE, cfg_sync1);
      send_word(fdc_pkg::OP_BYTE, cfg_sync2);
      send_word(fdc_pkg::OP_RESYNC, 8'hFF);
   endtask

   // register settings for each phase of the random traffic
   task automatic set_phase_config(int phase);
      logic [7:0] s;
      case (phase)
         0: ;  // keep the reset values
         1: begin
            write_csr(fdc_pkg::CSR_SYNC_FIRST, {8'($urandom), 8'h00});
            write_csr(fdc_pkg::CSR_SYNC_SECOND, {8'($urandom), 8'hFF});
            write_csr(fdc_pkg::CSR_LEN_LIMIT, 16'h0000);
         end
         2: begin
            write_csr(fdc_pkg::CSR_SYNC_FIRST, 16'h00FF);
            write_csr(fdc_pkg::CSR_SYNC_SECOND, 16'h0000);
            write_csr(fdc_pkg::CSR_LEN_LIMIT, 16'hFFFF);
            write_csr(CSR_UNUSED, 16'($urandom));   // must change nothing
         end
         3: begin
            // both sync bytes the same
            s = 8'($urandom);
            write_csr(fdc_pkg::CSR_SYNC_FIRST, {8'h00, s});
            write_csr(fdc_pkg::CSR_SYNC_SECOND, {8'h00, s});
            write_csr(fdc_pkg::CSR_LEN_LIMIT, 16'($urandom_range(0, 40)));
         end
         default: begin
            write_csr(fdc_pkg::CSR_SYNC_FIRST, 16'($urandom));
            write_csr(fdc_pkg::CSR_SYNC_SECOND, 16'($urandom));
            case ($urandom_range(0, 3))
               0: write_csr(fdc_pkg::CSR_LEN_LIMIT, 16'($urandom_range(0, 16)));
               1: write_csr(fdc_pkg::CSR_LEN_LIMIT, 16'($urandom_range(17, 300)));
               2: write_csr(fdc_pkg::CSR_LEN_LIMIT, fdc_pkg::LEN_LIMIT_RESET);
               default: write_csr(fdc_pkg::CSR_LEN_LIMIT, 16'hFFFF);
            endcase
         end
      endcase
   endtask

   // phases of well-formed frames with random content, mixed with damaged ones and noise
   task automatic test_random_traffic();
      int              phase;
      int              frames;
      int              r;
      frame_shape_type shape;
      phase         = 0;
      traffic_words = 0;
      while (traffic_words < RANDOM_WORDS) begin
         drain_results();
         quiet = 1'b0;
         set_phase_config(phase);
         quiet  = (phase % 4 == 3);
         frames = $urandom_range(10, 30);
         for (int f = 0; f < frames && traffic_words < RANDOM_WORDS; f++) begin
            r = $urandom_range(0, 99);
            if (r < 60)      shape = FRAME_GOOD;
            else if (r < 75) shape = FRAME_BAD_CRC;
            else if (r < 88) shape = FRAME_CUT;
            else             shape = FRAME_SLIP;
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
            if ($urandom_range(0, 19) == 0) send_chaos($urandom_range(4, 24));
            send_frame(shape, pick_length(), 8'($urandom), 8'($urandom));
            // sender holds off until the block has caught up
            if ($urandom_range(0, 49) == 0) drain_results();
         end
         phase++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.func    = fdc_pkg::OP_BYTE;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = fdc_pkg::CSR_SYNC_FIRST;
      csr_wdata      = 16'h0000;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_sync_slip();
      test_crc_mismatch();
      test_length_limit();
      test_resync();
      test_random_traffic();
      drain_results();

      if (mismatches == 0) begin
         $display("[frame_deframer_crc16] OK");
      end else begin
         $display("[frame_deframer_crc16] ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("[frame_deframer_crc16] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/fdc_pkg.sv
hw/rtl/fdc_if.sv
hw/rtl/fdc_front.sv
hw/rtl/fdc_queue.sv
hw/rtl/fdc_back.sv
hw/rtl/frame_deframer_crc16.sv
sim/frame_deframer_crc16_tb.sv
